### rtl/gated_sensor_moving_average_assert.svh
// Assertion helpers for the gated sensor moving average RTL.
// Each macro expects clk and rst_n in scope.
`ifndef GATED_SENSOR_MOVING_AVERAGE_ASSERT_SVH
`define GATED_SENSOR_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GSMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GSMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gsma_pkg.sv
package gsma_pkg;

  // Fixed field widths
  localparam int CH_W       = 2;
  localparam int CODE_W     = 12;
  localparam int SCALE_W    = 16;
  localparam int DIST_W     = 17;
  localparam int Q_FRAC     = 8;
  localparam int PROD_SH_W  = CODE_W + SCALE_W - Q_FRAC;
  localparam int BO_W       = DIST_W + 1;
  localparam int DSUM_W     = PROD_SH_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIST_W;
  localparam int NUM_OFFSETS = 4;

  // Distance saturation limits
  localparam logic signed [DSUM_W-1:0] SAT_LO = DSUM_W'(-65536);
  localparam logic signed [DSUM_W-1:0] SAT_HI = DSUM_W'(65535);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET3   = 3'd6;

  // Register reset values
  localparam logic [CODE_W-1:0]  MIN_VALID_RST = 12'd124;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 16'd256;

  typedef struct packed {
    logic [CODE_W-1:0]                    min_valid;
    logic [SCALE_W-1:0]                   scale;
    logic signed [DIST_W-1:0]             base;
    logic [NUM_OFFSETS-1:0][DIST_W-1:0]   offset;
  } cfg_t;

  // Input stage contents
  typedef struct packed {
    logic [CH_W-1:0]          ch;
    logic                     ok;
    logic                     old_valid;
    logic [PROD_SH_W-1:0]     prod_sh;
    logic signed [BO_W-1:0]   bo;
  } s1_t;

  // Sum stage tag
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            invalid;
  } s2_t;

endpackage

### rtl/gsma_ifs.sv
// Input channel: one tagged converter sample per transfer
interface gsma_in_if import gsma_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel;
  logic [CODE_W-1:0] sample_code;

  modport source (output valid, output channel, output sample_code, input ready);
  modport sink   (input valid, input channel, input sample_code, output ready);
endinterface

// Result channel: one filtered airgap per transfer
interface gsma_out_if import gsma_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          out_channel;
  logic                     invalid;
  logic signed [DIST_W-1:0] airgap_um;

  modport source (output valid, output out_channel, output invalid, output airgap_um,
                  input ready);
  modport sink   (input valid, input out_channel, input invalid, input airgap_um,
                  output ready);
endinterface

// Configuration write channel
interface gsma_cfg_if import gsma_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/gsma_ram.sv
module gsma_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/gsma_front.sv
module gsma_front import gsma_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  gsma_in_if.sink                                in_bus,
  input  cfg_t                                   cfg,
  input  logic                                   adv,
  output logic                                   s1_v,
  output s1_t                                    s1,
  output logic [$clog2(CHANNELS*WINDOW)-1:0]     s1_addr,
  output logic                                   rd_en,
  output logic [$clog2(CHANNELS*WINDOW)-1:0]     rd_addr
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = $clog2(WINDOW);
  localparam int AW = $clog2(CHANNELS*WINDOW);

  logic                 s1_v_r, s1_v_nxt;
  s1_t                  s1_r, s1_nxt;
  logic [AW-1:0]        s1_addr_r;
  logic [SW-1:0]        slot_r [CHANNELS];
  logic [CHANNELS-1:0]  wrap_r;

  logic                       accept;
  logic                       ok;
  logic [CW-1:0]              ch_idx;
  logic [SW-1:0]              slot_cur, slot_inc;
  logic                       slot_last;
  logic [AW-1:0]              addr;
  logic [CODE_W+SCALE_W-1:0]  prod;

  // Gate, scale product and boxcar slot lookup for the incoming sample
  always_comb begin
    accept    = in_bus.valid && in_bus.ready;
    ok        = (int'(in_bus.channel) < CHANNELS) && (in_bus.sample_code >= cfg.min_valid);
    ch_idx    = CW'(in_bus.channel);
    slot_cur  = slot_r[ch_idx];
    slot_last = (slot_cur == SW'(WINDOW - 1));
    slot_inc  = slot_last ? '0 : slot_cur + 1'b1;
    addr      = AW'(int'(ch_idx) * WINDOW + int'(slot_cur));
    prod      = in_bus.sample_code * cfg.scale;

    s1_nxt.ch        = in_bus.channel;
    s1_nxt.ok        = ok;
    s1_nxt.old_valid = wrap_r[ch_idx];
    s1_nxt.prod_sh   = prod[CODE_W+SCALE_W-1:Q_FRAC];
    s1_nxt.bo        = BO_W'(cfg.base) + BO_W'($signed(cfg.offset[in_bus.channel]));

    s1_v_nxt = accept ? 1'b1 : (adv ? 1'b0 : s1_v_r);
  end

  assign in_bus.ready = !s1_v_r || adv;
  assign rd_en        = accept && ok;
  assign rd_addr      = addr;

  // Control: stage valid, per-channel slot and wrap flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      wrap_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        slot_r[i] <= '0;
      end
    end else begin
      s1_v_r <= s1_v_nxt;
      if (accept && ok) begin
        slot_r[ch_idx] <= slot_inc;
        if (slot_last) begin
          wrap_r[ch_idx] <= 1'b1;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r      <= s1_nxt;
      s1_addr_r <= addr;
    end
  end

  assign s1_v    = s1_v_r;
  assign s1      = s1_r;
  assign s1_addr = s1_addr_r;

endmodule

### rtl/gsma_accum.sv
module gsma_accum import gsma_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 10
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        s1_v,
  input  s1_t                                         s1,
  input  logic [$clog2(CHANNELS*WINDOW)-1:0]          s1_addr,
  input  logic [DIST_W-1:0]                           rdata,
  input  logic                                        s2_free,
  output logic                                        adv,
  output logic                                        we,
  output logic [$clog2(CHANNELS*WINDOW)-1:0]          waddr,
  output logic [DIST_W-1:0]                           wdata,
  output logic                                        s2_v,
  output s2_t                                         s2,
  output logic signed [DIST_W+$clog2(WINDOW)-1:0]     s2_sum
);

  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUMW = DIST_W + $clog2(WINDOW);

  logic signed [SUMW-1:0]  sums_r [CHANNELS];
  logic                    s2_v_r, s2_v_nxt;
  s2_t                     s2_r;
  logic signed [SUMW-1:0]  s2_sum_r;

  logic [CW-1:0]             ch_idx;
  logic signed [DSUM_W-1:0]  dist_raw;
  logic signed [DIST_W-1:0]  dist_sat, old;
  logic signed [SUMW-1:0]    sum_nxt;

  // Distance with saturation, then running sum update
  always_comb begin
    ch_idx   = CW'(s1.ch);
    dist_raw = $signed({2'b00, s1.prod_sh}) + DSUM_W'(s1.bo);
    if (dist_raw < SAT_LO) begin
      dist_sat = SAT_LO[DIST_W-1:0];
    end else if (dist_raw > SAT_HI) begin
      dist_sat = SAT_HI[DIST_W-1:0];
    end else begin
      dist_sat = dist_raw[DIST_W-1:0];
    end
    // a slot not yet written since reset counts as zero
    old     = s1.old_valid ? $signed(rdata) : '0;
    sum_nxt = sums_r[ch_idx] + SUMW'(dist_sat) - SUMW'(old);

    adv      = s1_v && s2_free;
    s2_v_nxt = adv ? 1'b1 : (s2_free ? 1'b0 : s2_v_r);
  end

  assign we    = adv && s1.ok;
  assign waddr = s1_addr;
  assign wdata = dist_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sums_r[i] <= '0;
      end
    end else begin
      s2_v_r <= s2_v_nxt;
      if (we) begin
        sums_r[ch_idx] <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r.ch      <= s1.ch;
      s2_r.invalid <= !s1.ok;
      s2_sum_r     <= s1.ok ? sum_nxt : '0;
    end
  end

  assign s2_v   = s2_v_r;
  assign s2     = s2_r;
  assign s2_sum = s2_sum_r;

endmodule

### rtl/gsma_mean.sv
module gsma_mean import gsma_pkg::*; #(
  parameter int WINDOW = 10
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     s2_v,
  input  s2_t                                      s2,
  input  logic signed [DIST_W+$clog2(WINDOW)-1:0]  s2_sum,
  output logic                                     s2_free,
  gsma_out_if.source                               out_bus
);

  // floor(a / WINDOW) = (a * RECIP) >> SHIFT, exact for a below 2**MAG_W
  localparam int SUMW  = DIST_W + $clog2(WINDOW);
  localparam int MAG_W = SUMW - 1;
  localparam int L     = $clog2(WINDOW);
  localparam int SHIFT = MAG_W + L;
  localparam int RW    = MAG_W + 1;
  localparam int PW    = MAG_W + RW;
  localparam int QW    = PW - SHIFT;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) / WINDOW) + 64'd1;
  localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

  logic                      out_v_r, out_v_nxt;
  logic [CH_W-1:0]           out_ch_r;
  logic                      out_inv_r;
  logic signed [DIST_W-1:0]  out_gap_r;

  logic                   out_load;
  logic                   neg;
  logic [MAG_W-1:0]       mag;
  logic [PW-1:0]          prod;
  logic [QW-1:0]          quo;
  logic [SUMW-1:0]        mean;

  // Floor division of the window sum; negative sums go through one's complement
  always_comb begin
    neg  = s2_sum[SUMW-1];
    mag  = neg ? ~s2_sum[MAG_W-1:0] : s2_sum[MAG_W-1:0];
    prod = mag * RECIP;
    quo  = prod[PW-1:SHIFT];
    mean = neg ? ~SUMW'(quo) : SUMW'(quo);

    out_load  = s2_v && (!out_v_r || out_bus.ready);
    out_v_nxt = out_load ? 1'b1 : (out_bus.ready ? 1'b0 : out_v_r);
  end

  assign s2_free = !s2_v || !out_v_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r  <= s2.ch;
      out_inv_r <= s2.invalid;
      out_gap_r <= s2.invalid ? '0 : $signed(mean[DIST_W-1:0]);
    end
  end

  assign out_bus.valid       = out_v_r;
  assign out_bus.out_channel = out_ch_r;
  assign out_bus.invalid     = out_inv_r;
  assign out_bus.airgap_um   = out_gap_r;

endmodule

### rtl/gated_sensor_moving_average.sv
// Result path: input, sum and output registers in that order; a full output register stalls them.
// Throughput: one sample per cycle while the output is taken, any channel order; limited by the single
//   read and single write port of the window store, one of each per sample that passes the gate.
// Reset: registers return to their defaults, slots, running sums and fill flags clear
//   at once; window entries read as zero until written, so no clearing pass runs.
`include "gated_sensor_moving_average_assert.svh"

module gated_sensor_moving_average import gsma_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  gsma_in_if.sink     in_bus,
  gsma_out_if.source  out_bus,
  gsma_cfg_if.sink    cfg_bus
);

  localparam int AW   = $clog2(CHANNELS*WINDOW);
  localparam int SUMW = DIST_W + $clog2(WINDOW);

  cfg_t cfg_r;

  logic                    s1_v, adv, rd_en, we, s2_v, s2_free;
  s1_t                     s1;
  s2_t                     s2;
  logic [AW-1:0]           s1_addr, rd_addr, waddr;
  logic [DIST_W-1:0]       rdata, wdata;
  logic signed [SUMW-1:0]  s2_sum;

  // Configuration registers, to be written by the user only while the block is idle; the block does not enforce it
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_valid <= MIN_VALID_RST;
      cfg_r.scale     <= SCALE_RST;
      cfg_r.base      <= '0;
      cfg_r.offset    <= '0;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_MIN_VALID: cfg_r.min_valid <= cfg_bus.data[CODE_W-1:0];
        REG_SCALE:     cfg_r.scale     <= cfg_bus.data[SCALE_W-1:0];
        REG_BASE:      cfg_r.base      <= $signed(cfg_bus.data);
        REG_OFFSET0:   cfg_r.offset[0] <= cfg_bus.data;
        REG_OFFSET1:   cfg_r.offset[1] <= cfg_bus.data;
        REG_OFFSET2:   cfg_r.offset[2] <= cfg_bus.data;
        REG_OFFSET3:   cfg_r.offset[3] <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  gsma_front #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .cfg     (cfg_r),
    .adv     (adv),
    .s1_v    (s1_v),
    .s1      (s1),
    .s1_addr (s1_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  // Boxcar window store, one row of WINDOW entries per channel
  gsma_ram #(.WIDTH(DIST_W), .DEPTH(CHANNELS*WINDOW)) u_window (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .rd_en (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  gsma_accum #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1_v    (s1_v),
    .s1      (s1),
    .s1_addr (s1_addr),
    .rdata   (rdata),
    .s2_free (s2_free),
    .adv     (adv),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .s2_v    (s2_v),
    .s2      (s2),
    .s2_sum  (s2_sum)
  );

  gsma_mean #(.WINDOW(WINDOW)) u_mean (
    .clk     (clk),
    .rst_n   (rst_n),
    .s2_v    (s2_v),
    .s2      (s2),
    .s2_sum  (s2_sum),
    .s2_free (s2_free),
    .out_bus (out_bus)
  );

  // Pipeline occupancy and result checks
  `GSMA_ASSERT_NEXT(a_accept_fills_s1, in_bus.valid && in_bus.ready, s1_v, "transfer lost at input stage")
  `GSMA_ASSERT_NEXT(a_adv_fills_s2, adv, s2_v, "item lost between input and sum stage")
  `GSMA_ASSERT_NEXT(a_s2_fills_out, s2_v && !out_bus.valid, out_bus.valid, "output register did not load")
  `GSMA_ASSERT_NOW(a_invalid_zero, out_bus.valid && out_bus.invalid, out_bus.airgap_um == '0, "invalid result with nonzero distance")
  `GSMA_ASSERT_NOW(a_write_on_adv, we, adv && s1_v && s1.ok, "window write without a valid sample")

endmodule
